@@ rtl/core/sp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp_pkg
// Shared types, constants, the exponent table function and the divider
// step for the sigmoid-product membership evaluator.
// ----------------------------------------------------------------------------
package sp_pkg;

    // Fixed field widths
    localparam int VALUE_WIDTH = 16;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    // Fixed-point constants
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic signed [33:0] EXP_LIMIT_Q18 = 34'sd4194304;
    localparam logic [16:0] DEGREE_MAX = 17'd32768;

    // Register indexes
    localparam logic [2:0] REG_LEFT   = 3'd0;
    localparam logic [2:0] REG_RISE   = 3'd1;
    localparam logic [2:0] REG_FALL   = 3'd2;
    localparam logic [2:0] REG_RIGHT  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    typedef struct packed {
        logic signed [15:0] left_inflection;
        logic signed [15:0] rising_slope;
        logic signed [15:0] falling_slope;
        logic signed [15:0] right_inflection;
        logic [15:0]        peak_height;
    } sp_cfg_t;

    // One restoring-division lane: 2^60 / dvs, one quotient bit per cell
    typedef struct packed {
        logic [54:0] rem;
        logic [54:0] dvs;
        logic [30:0] quo;
        logic        zero;
    } sp_lane_t;

    typedef struct packed {
        sp_lane_t rise;
        sp_lane_t fall;
    } sp_pair_t;

    // Entry k of 2^(k/depth) in Q30, depth = 2^shift (elaboration only)
    function automatic logic [30:0] exp_entry(input int unsigned k, input int unsigned shift);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] sum;
        y = (64'(k) * LN2_Q30) >> shift;
        term = ONE_Q30;
        sum = ONE_Q30;
        for (int i = 1; i <= 20; i++)
        begin
            term = ((term * y) >> 30) / 64'(i);
            sum = sum + term;
        end
        return sum[30:0];
    endfunction

    // One restoring step: shift remainder, compare, subtract
    function automatic sp_lane_t div_step(input sp_lane_t l);
        sp_lane_t   r;
        logic [55:0] sh;
        logic [55:0] diff;
        r = l;
        sh = {l.rem, 1'b0};
        diff = sh - {1'b0, l.dvs};
        if (sh >= {1'b0, l.dvs})
        begin
            r.rem = diff[54:0];
            r.quo = {l.quo[29:0], 1'b1};
        end
        else
        begin
            r.rem = sh[54:0];
            r.quo = {l.quo[29:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/sp_sample_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp_sample_if
// Input channel: one crisp value per word.
// ----------------------------------------------------------------------------
interface sp_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] crisp_value;

    modport source (output valid, output crisp_value, input ready);
    modport sink (input valid, input crisp_value, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sp_result_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp_result_if
// Output channel: one membership degree per word.
// ----------------------------------------------------------------------------
interface sp_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] degree;

    modport source (output valid, output degree, input ready);
    modport sink (input valid, input degree, output ready);
endinterface
`default_nettype wire

@@ rtl/core/sigmoid_product_membership.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sigmoid_product_membership
// Fuzzy membership degree of a crisp value under a product of two sigmoids.
// ----------------------------------------------------------------------------
//  channel  | direction | word
//  sample   | in        | crisp_value, signed Q8.8
//  result   | out       | degree, unsigned Q1.15
//  apb      | in        | five 16-bit registers at 4*i
//
//  One word accepted per cycle unless the result is stalled; the pipeline
//  is 5 front stages + 31 divider cells + 3 product/output stages.
//  The 31-cell restoring divider chain sets the latency.
//  A stalled result freezes the whole pipeline; sample.ready follows it.
//  Reset clears valid bits and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module sigmoid_product_membership #(
    parameter int EXP_TABLE_DEPTH = sp_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    sp_sample_if.sink        sample,
    sp_result_if.source      result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int CELLS = 31;

    sp_pkg::sp_cfg_t  cfg;
    logic             adv;
    logic             chain_valid [CELLS + 1];
    sp_pkg::sp_pair_t chain_pair [CELLS + 1];
    logic [2:0]       pv_reg;
    logic [30:0]      fa, fb;
    logic [46:0]      hp;
    logic [30:0]      r1_reg, r1_next;
    logic [30:0]      fb_reg;
    logic [61:0]      r2_reg, r2_next;
    logic [61:0]      rsum;
    logic [16:0]      rq;
    logic [15:0]      deg_reg, deg_next;

    // Whole pipeline moves unless the result word is held
    assign adv = !pv_reg[2] || result.ready;
    assign sample.ready = adv;

    sp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sp_exp_front #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sample.valid),
        .x         (sample.crisp_value),
        .cfg       (cfg),
        .out_valid (chain_valid[0]),
        .out_pair  (chain_pair[0])
    );

    // Divider chain
    for (genvar c = 0; c < CELLS; c++)
    begin : g_cell
        sp_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (chain_valid[c]),
            .in_pair   (chain_pair[c]),
            .out_valid (chain_valid[c + 1]),
            .out_pair  (chain_pair[c + 1])
        );
    end

    // Height times both factors, round and clamp
    always_comb
    begin
        fa = chain_pair[CELLS].rise.zero ? 31'd0 : chain_pair[CELLS].rise.quo;
        fb = chain_pair[CELLS].fall.zero ? 31'd0 : chain_pair[CELLS].fall.quo;
        hp = 47'(cfg.peak_height) * 47'(fa);
        r1_next = hp[45:15];
        r2_next = 62'(r1_reg) * 62'(fb_reg);
        rsum = r2_reg + (62'd1 << 44);
        rq = rsum[61:45];
        if (rq > sp_pkg::DEGREE_MAX)
            deg_next = 16'(sp_pkg::DEGREE_MAX);
        else
            deg_next = rq[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= '0;
        else if (adv)
            pv_reg <= {pv_reg[1:0], chain_valid[CELLS]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg <= r1_next;
            fb_reg <= fb;
            r2_reg <= r2_next;
            deg_reg <= deg_next;
        end
    end

    assign result.valid = pv_reg[2];
    assign result.degree = deg_reg;

`ifndef SYNTH
    // Degree never exceeds one
    a_deg_max: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.degree <= 16'd32768))
        else $error("degree above one");

    // Divider never yields a factor above one
    a_quo_max: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[CELLS] |-> (chain_pair[CELLS].rise.quo <= 31'h40000000
                                && chain_pair[CELLS].fall.quo <= 31'h40000000))
        else $error("sigmoid factor above one");

    // Stall freezes the tail of the pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pv_reg) && $stable(deg_reg))
        else $error("pipeline moved while stalled");

    // Chain output lands in the product stage on advance
    a_chain_to_prod: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> pv_reg[0] == $past(chain_valid[CELLS]))
        else $error("word lost between divider and product stage");
`endif
endmodule
`default_nettype wire

@@ rtl/core/sp_apb_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp_apb_regs
// APB register file holding the inflection points, slopes and height.
// ----------------------------------------------------------------------------
module sp_apb_regs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output sp_pkg::sp_cfg_t  cfg
);
    sp_pkg::sp_cfg_t cfg_reg;
    sp_pkg::sp_cfg_t cfg_next;
    logic            wr_en;
    logic [2:0]      idx;

    assign pready = 1'b1;
    assign idx = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign cfg = cfg_reg;

    // Decode write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                sp_pkg::REG_LEFT:   cfg_next.left_inflection = pwdata[15:0];
                sp_pkg::REG_RISE:   cfg_next.rising_slope = pwdata[15:0];
                sp_pkg::REG_FALL:   cfg_next.falling_slope = pwdata[15:0];
                sp_pkg::REG_RIGHT:  cfg_next.right_inflection = pwdata[15:0];
                sp_pkg::REG_HEIGHT: cfg_next.peak_height = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.left_inflection <= 16'sd0;
            cfg_reg.rising_slope <= 16'sd1024;
            cfg_reg.falling_slope <= -16'sd1024;
            cfg_reg.right_inflection <= 16'sd0;
            cfg_reg.peak_height <= 16'd32768;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            sp_pkg::REG_LEFT:   prdata = {16'd0, cfg_reg.left_inflection};
            sp_pkg::REG_RISE:   prdata = {16'd0, cfg_reg.rising_slope};
            sp_pkg::REG_FALL:   prdata = {16'd0, cfg_reg.falling_slope};
            sp_pkg::REG_RIGHT:  prdata = {16'd0, cfg_reg.right_inflection};
            sp_pkg::REG_HEIGHT: prdata = {16'd0, cfg_reg.peak_height};
            default:            prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/core/sp_exp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp_exp_front
// Five-stage front end: offset, slope product, base-2 scaling, table read
// and shift, giving the divisor 1 + exp(z) for both sigmoids.
// ----------------------------------------------------------------------------
module sp_exp_front #(
    parameter int EXP_TABLE_DEPTH = sp_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               in_valid,
    input  wire logic signed [15:0] x,
    input  wire sp_pkg::sp_cfg_t    cfg,
    output logic                    out_valid,
    output sp_pkg::sp_pair_t        out_pair
);
    // Depth must be a power of two, which is not checked here; index is the top fraction bits
    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

    logic [30:0]        tbl [EXP_TABLE_DEPTH];
    logic [4:0]         v_reg;
    logic signed [15:0] infl [2];
    logic signed [15:0] slope [2];
    logic signed [16:0] d_reg [2];
    logic signed [16:0] d_next [2];
    logic signed [32:0] prod [2];
    logic signed [33:0] z_reg [2];
    logic signed [33:0] z_next [2];
    logic signed [54:0] w_reg [2];
    logic signed [54:0] w_next [2];
    logic [1:0]         hi3_reg, lo3_reg, hi4_reg, lo4_reg;
    logic [1:0]         hi3_next, lo3_next;
    logic [30:0]        t_reg [2];
    logic [30:0]        t_next [2];
    logic signed [5:0]  ip_reg [2];
    logic signed [5:0]  ip_next [2];
    logic [5:0]         nip [2];
    logic [54:0]        e_val [2];
    sp_pkg::sp_lane_t   lane_next [2];
    sp_pkg::sp_pair_t   pair_reg;

    // Constant exponent table
    for (genvar k = 0; k < EXP_TABLE_DEPTH; k++)
    begin : g_tbl
        assign tbl[k] = sp_pkg::exp_entry(k, IDX_W);
    end

    assign infl[0] = cfg.left_inflection;
    assign infl[1] = cfg.right_inflection;
    assign slope[0] = cfg.rising_slope;
    assign slope[1] = cfg.falling_slope;

    // Stage logic for both lanes
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            d_next[i] = 17'(x) - 17'(infl[i]);
            prod[i] = slope[i] * d_reg[i];
            z_next[i] = -(34'(prod[i]));
            hi3_next[i] = (z_reg[i] >= sp_pkg::EXP_LIMIT_Q18);
            lo3_next[i] = (z_reg[i] <= -sp_pkg::EXP_LIMIT_Q18);
            w_next[i] = $signed(z_reg[i][22:0]) * sp_pkg::LOG2E_Q30;
            t_next[i] = tbl[w_reg[i][47 -: IDX_W]];
            ip_next[i] = $signed(w_reg[i][53:48]);
            nip[i] = 6'(-ip_reg[i]);
            if (ip_reg[i][5])
                e_val[i] = 55'(t_reg[i] >> nip[i][4:0]);
            else
                e_val[i] = 55'(t_reg[i]) << ip_reg[i][4:0];
            lane_next[i].rem = 55'(64'd1 << 29);
            lane_next[i].dvs = lo4_reg[i] ? 55'(sp_pkg::ONE_Q30)
                                          : 55'(sp_pkg::ONE_Q30) + e_val[i];
            lane_next[i].quo = '0;
            lane_next[i].zero = hi4_reg[i];
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[3:0], in_valid};
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= d_next;
            z_reg <= z_next;
            w_reg <= w_next;
            hi3_reg <= hi3_next;
            lo3_reg <= lo3_next;
            t_reg <= t_next;
            ip_reg <= ip_next;
            hi4_reg <= hi3_reg;
            lo4_reg <= lo3_reg;
            pair_reg.rise <= lane_next[0];
            pair_reg.fall <= lane_next[1];
        end
    end

    assign out_valid = v_reg[4];
    assign out_pair = pair_reg;
endmodule
`default_nettype wire

@@ rtl/core/sp_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sp_div_cell
// One cell of the divider chain: resolves one quotient bit of both
// sigmoid factors and hands the word to the next cell.
// ----------------------------------------------------------------------------
module sp_div_cell (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire sp_pkg::sp_pair_t in_pair,
    output logic                  out_valid,
    output sp_pkg::sp_pair_t      out_pair
);
    logic             valid_reg;
    sp_pkg::sp_pair_t pair_reg;
    sp_pkg::sp_pair_t pair_next;

    // One restoring step per lane
    always_comb
    begin
        pair_next.rise = sp_pkg::div_step(in_pair.rise);
        pair_next.fall = sp_pkg::div_step(in_pair.fall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            pair_reg <= pair_next;
    end

    assign out_valid = valid_reg;
    assign out_pair = pair_reg;
endmodule
`default_nettype wire
